>>> sv/ucs_pkg.sv
// Shared types, character codes and sizes for the URI component splitter.
`default_nettype none

package ucs_pkg;

  // results one input byte can cause at most
  localparam int MAX_RES     = 3;
  localparam int RES_W       = $clog2(MAX_RES + 1);
  localparam int IDX_W       = $clog2(MAX_RES);
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [2:0] {
    PH_SCHEME,
    PH_REST,
    PH_AUTH,
    PH_PATH,
    PH_QUERY,
    PH_FRAG
  } phase_t;

  typedef enum logic [2:0] {
    COMP_SCHEME,
    COMP_AUTH,
    COMP_PATH,
    COMP_KEY,
    COMP_VALUE,
    COMP_FRAG
  } comp_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NO_SCHEME,
    ST_SCHEME_CHAR,
    ST_SCHEME_ALPHA,
    ST_EMPTY_QUERY,
    ST_QUERY_CHAR,
    ST_FRAG_CHAR
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } char_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       data_valid;
    comp_t      component;
    logic       pair_start;
    status_t    status;
    logic       last;
  } part_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       data_valid;
    comp_t      component;
    logic       pair_start;
  } slot_t;

  // all results caused by one input byte
  typedef struct packed {
    slot_t [MAX_RES-1:0] slot;
    logic  [RES_W-1:0]   n;
    status_t             status;
    logic                last;
  } bundle_t;

endpackage

`default_nettype wire

>>> sv/ucs_front.sv
// Front end: parses one byte per cycle, while the queue has room, into a bundle of tagged results.
`default_nettype none

module ucs_front import ucs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    char_valid,
  output logic         char_ready,
  input  wire char_t   char_data,
  output logic         push_valid,
  input  wire logic    push_ready,
  output bundle_t      push_data
);

  typedef struct packed {
    phase_t     phase;
    logic       scheme_nonempty;
    logic       scheme_bad_char;
    logic       scheme_bad_start;
    logic       slash_pending;
    logic [1:0] pct_count;
    logic [7:0] held_digit;
    logic       query_nonempty;
    logic       pair_open;
    logic       pair_dropped;
    logic       in_value;
    status_t    first_error;
  } pstate_t;

  typedef struct packed {
    pstate_t st;
    bundle_t bd;
  } work_t;

  localparam pstate_t PSTATE_RESET = '{
    phase:            PH_SCHEME,
    scheme_nonempty:  1'b0,
    scheme_bad_char:  1'b0,
    scheme_bad_start: 1'b0,
    slash_pending:    1'b0,
    pct_count:        2'd0,
    held_digit:       8'd0,
    query_nonempty:   1'b0,
    pair_open:        1'b0,
    pair_dropped:     1'b0,
    in_value:         1'b0,
    first_error:      ST_OK
  };

  pstate_t st;
  pstate_t st_next;
  work_t   w;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_scheme_char(logic [7:0] c);
    return is_alnum(c) || c == 8'h2B || c == 8'h2D || c == 8'h2E;
  endfunction

  function automatic logic is_qf_char(logic [7:0] c);
    return is_alnum(c) || (c inside {8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h21, 8'h24,
                                     8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B,
                                     8'h2C, 8'h3B, 8'h3D, 8'h3A, 8'h40, 8'h2F,
                                     8'h3F});
  endfunction

  // {is_hex, nibble}
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic work_t set_err(work_t wi, status_t e);
    work_t wo;
    wo = wi;
    if (wo.st.first_error == ST_OK) wo.st.first_error = e;
    return wo;
  endfunction

  function automatic work_t put(work_t wi, logic [7:0] b, comp_t c, logic s);
    work_t wo;
    wo = wi;
    if (wo.bd.n < RES_W'(MAX_RES)) begin
      wo.bd.slot[wo.bd.n[IDX_W-1:0]] = '{out_byte: b, data_valid: 1'b1,
                                         component: c, pair_start: s};
      wo.bd.n = wo.bd.n + 1'b1;
    end
    return wo;
  endfunction

  function automatic work_t emit(work_t wi, logic [7:0] b);
    work_t wo;
    wo = wi;
    unique case (wo.st.phase)
      PH_AUTH: wo = put(wo, b, COMP_AUTH, 1'b0);
      PH_PATH: wo = put(wo, b, COMP_PATH, 1'b0);
      PH_QUERY: begin
        if (!wo.st.pair_dropped) begin
          if (wo.st.in_value) begin
            wo = put(wo, b, COMP_VALUE, 1'b0);
          end else begin
            wo = put(wo, b, COMP_KEY, !wo.st.pair_open);
            wo.st.pair_open = 1'b1;
          end
        end
      end
      PH_FRAG: wo = put(wo, b, COMP_FRAG, 1'b0);
      default: wo = put(wo, b, COMP_SCHEME, 1'b0);
    endcase
    return wo;
  endfunction

  // pending percent sequence goes out verbatim
  function automatic work_t flush(work_t wi);
    work_t wo;
    wo = wi;
    if (wo.st.pct_count != 2'd0) wo = emit(wo, CH_PCT);
    if (wo.st.pct_count == 2'd2) wo = emit(wo, wo.st.held_digit);
    wo.st.pct_count = 2'd0;
    return wo;
  endfunction

  function automatic work_t feed(work_t wi, logic [7:0] b);
    work_t      wo;
    logic [4:0] hv;
    logic [4:0] hh;
    logic       done;
    wo   = wi;
    hv   = hex_val(b);
    hh   = hex_val(wi.st.held_digit);
    done = 1'b0;
    if (wo.st.pct_count != 2'd0) begin
      if (wo.st.pct_count == 2'd1 && hv[4]) begin
        wo.st.held_digit = b;
        wo.st.pct_count  = 2'd2;
        done = 1'b1;
      end else if (wo.st.pct_count == 2'd2 && hv[4]) begin
        wo.st.pct_count = 2'd0;
        wo = emit(wo, {(hh[4] ? hh[3:0] : 4'h0), hv[3:0]});
        done = 1'b1;
      end else begin
        wo = flush(wo);
      end
    end
    if (!done) begin
      if (b == CH_PCT) wo.st.pct_count = 2'd1;
      else wo = emit(wo, b);
    end
    return wo;
  endfunction

  function automatic work_t path_byte(work_t wi, logic [7:0] b);
    work_t wo;
    wo = wi;
    wo.st.phase = PH_PATH;
    if (b == CH_QMARK || b == CH_HASH) begin
      wo = flush(wo);
      if (b == CH_QMARK) begin
        wo.st.phase          = PH_QUERY;
        wo.st.query_nonempty = 1'b0;
        wo.st.pair_open      = 1'b0;
        wo.st.pair_dropped   = 1'b0;
        wo.st.in_value       = 1'b0;
      end else begin
        wo.st.phase = PH_FRAG;
      end
    end else begin
      wo = feed(wo, b);
    end
    return wo;
  endfunction

  function automatic work_t process(work_t wi, logic [7:0] b);
    work_t wo;
    wo = wi;
    unique case (wo.st.phase)
      PH_SCHEME: begin
        if (b == CH_COLON) begin
          if (!wo.st.scheme_nonempty) wo = set_err(wo, ST_NO_SCHEME);
          else if (wo.st.scheme_bad_char) wo = set_err(wo, ST_SCHEME_CHAR);
          else if (wo.st.scheme_bad_start) wo = set_err(wo, ST_SCHEME_ALPHA);
          wo.st.phase = PH_REST;
        end else begin
          if (!wo.st.scheme_nonempty && !is_alpha(b)) wo.st.scheme_bad_start = 1'b1;
          wo.st.scheme_nonempty = 1'b1;
          if (!is_scheme_char(b)) wo.st.scheme_bad_char = 1'b1;
          wo = put(wo, b, COMP_SCHEME, 1'b0);
        end
      end
      PH_REST: begin
        if (wo.st.slash_pending) begin
          wo.st.slash_pending = 1'b0;
          if (b == CH_SLASH) begin
            wo.st.phase = PH_AUTH;
          end else begin
            wo.st.phase = PH_PATH;
            wo = emit(wo, CH_SLASH);
            wo = path_byte(wo, b);
          end
        end else if (b == CH_SLASH) begin
          wo.st.slash_pending = 1'b1;
        end else begin
          wo = path_byte(wo, b);
        end
      end
      PH_AUTH: begin
        if (b == CH_SLASH || b == CH_QMARK || b == CH_HASH) begin
          wo = flush(wo);
          wo = path_byte(wo, b);
        end else begin
          wo = feed(wo, b);
        end
      end
      PH_PATH: wo = path_byte(wo, b);
      PH_QUERY: begin
        if (b == CH_HASH) begin
          wo = flush(wo);
          if (!wo.st.query_nonempty) wo = set_err(wo, ST_EMPTY_QUERY);
          wo.st.phase = PH_FRAG;
        end else begin
          wo.st.query_nonempty = 1'b1;
          if (!is_qf_char(b) && b != CH_PCT) wo = set_err(wo, ST_QUERY_CHAR);
          if (b == CH_AMP) begin
            wo = flush(wo);
            wo.st.pair_open    = 1'b0;
            wo.st.pair_dropped = 1'b0;
            wo.st.in_value     = 1'b0;
          end else if (b == CH_EQ && !wo.st.in_value) begin
            wo = flush(wo);
            // empty key: drop the whole pair
            if (!wo.st.pair_open) wo.st.pair_dropped = 1'b1;
            wo.st.in_value = 1'b1;
          end else if (!wo.st.pair_dropped) begin
            wo = feed(wo, b);
          end
        end
      end
      default: begin
        wo.st.phase = PH_FRAG;
        if (!is_qf_char(b) && b != CH_PCT) wo = set_err(wo, ST_FRAG_CHAR);
        wo = feed(wo, b);
      end
    endcase
    return wo;
  endfunction

  always_comb begin
    w.st = st;
    w.bd = '0;
    w = process(w, char_data.in_byte);
    if (char_data.last_byte) begin
      w = flush(w);
      if (w.st.phase == PH_REST && w.st.slash_pending) begin
        w.st.slash_pending = 1'b0;
        w.st.phase = PH_PATH;
        w = emit(w, CH_SLASH);
      end
      if (w.st.phase == PH_SCHEME) w = set_err(w, ST_NO_SCHEME);
      if (w.st.phase == PH_QUERY && !w.st.query_nonempty) w = set_err(w, ST_EMPTY_QUERY);
      if (w.bd.n == '0) begin
        // status-only transaction
        w.bd.slot[0] = '{out_byte: 8'd0, data_valid: 1'b0,
                         component: COMP_SCHEME, pair_start: 1'b0};
        w.bd.n = RES_W'(1);
      end
    end
    w.bd.status = w.st.first_error;
    w.bd.last   = char_data.last_byte;
    st_next     = char_data.last_byte ? PSTATE_RESET : w.st;
    push_data   = w.bd;
    push_valid  = char_valid && (w.bd.n != '0);
    char_ready  = push_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PSTATE_RESET;
    end else if (char_valid && char_ready) begin
      st <= st_next;
    end
  end

`ifndef ASSERT_OFF
  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_ready && char_data.last_byte)
      |=> (st.phase == PH_SCHEME && st.first_error == ST_OK && st.pct_count == 2'd0))
    else $error("parser state not cleared after last byte");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    st.pct_count != 2'd3)
    else $error("percent counter out of range");

  a_slash_phase: assert property (@(posedge clk) disable iff (rst)
    st.slash_pending |-> st.phase == PH_REST)
    else $error("slash pending outside the post-colon phase");
`endif

endmodule

`default_nettype wire

>>> sv/ucs_queue.sv
// Short register queue of result bundles between front and back end.
`default_nettype none

module ucs_queue import ucs_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push_valid,
  output logic         push_ready,
  input  wire bundle_t push_data,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output bundle_t      pop_data
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  bundle_t         entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count exceeds depth");
`endif

endmodule

`default_nettype wire

>>> sv/ucs_back.sv
// Back end: unpacks queued bundles into one result transaction per cycle while the output is not stalled.
`default_nettype none

module ucs_back import ucs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    q_valid,
  output logic         q_ready,
  input  wire bundle_t q_data,
  output logic         part_valid,
  input  wire logic    part_ready,
  output part_t        part_data
);

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             at_end;
  slot_t            cur;

  assign cur     = q_data.slot[idx];
  assign at_end  = (RES_W'(idx) == q_data.n - 1'b1);
  assign load    = q_valid && (!part_valid || part_ready);
  assign q_ready = load && at_end;

  always_ff @(posedge clk) begin
    if (load) begin
      part_data <= '{out_byte:   cur.out_byte,
                     data_valid: cur.data_valid,
                     component:  cur.component,
                     pair_start: cur.pair_start,
                     status:     q_data.status,
                     last:       q_data.last && at_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (load) begin
        part_valid <= 1'b1;
        idx        <= at_end ? '0 : idx + 1'b1;
      end else if (part_ready) begin
        part_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> RES_W'(idx) < q_data.n)
    else $error("result index beyond bundle size");
`endif

endmodule

`default_nettype wire

>>> sv/uri_component_splitter.sv
// After its byte is accepted, a result is held in a queue entry and then in the output register.
// The front takes one byte per cycle while the queue has room; the back end sends one result per cycle
// while the output is not stalled, so a byte that yields k results (up to 3, on a broken triplet) sends all k in turn.
// Bytes yielding no result (scheme colon, the "//" pair) cost the back end nothing.
// Reset (rst, synchronous): parser returns to the scheme phase, queue and output are emptied.
`default_nettype none

module uri_component_splitter import ucs_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  char_valid,
  output logic       char_ready,
  input  wire char_t char_data,
  output logic       part_valid,
  input  wire logic  part_ready,
  output part_t      part_data
);

  logic    push_valid;
  logic    push_ready;
  bundle_t push_data;
  logic    q_valid;
  logic    q_ready;
  bundle_t q_data;

  ucs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ucs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  ucs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .part_valid (part_valid),
    .part_ready (part_ready),
    .part_data  (part_data)
  );

endmodule

`default_nettype wire
